### design/rle_triplet_scanline_expander_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the scanline expander
// Shared concurrent assertion forms, clocked on clk.
// ----------------------------------------------------------------------------
`ifndef RLE_TRIPLET_SCANLINE_EXPANDER_MACROS_SVH
`define RLE_TRIPLET_SCANLINE_EXPANDER_MACROS_SVH

// Checked outside reset only.
`define RTE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define RTE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/rte_pkg.sv
// ----------------------------------------------------------------------------
// rte_pkg
// Types and constants of the run-length scanline expander.
// ----------------------------------------------------------------------------
`default_nettype none

package rte_pkg;

  // Default scanline width in pixels (legal range 64..127)
  localparam int RTE_LINE_WIDTH = 96;

  // Field widths
  localparam int BYTE_W  = 8;
  localparam int COLOR_W = 16;
  localparam int COL_W   = 7;
  localparam int ROOM_W  = COL_W + 1;   // holds a full line width
  localparam int OUT_W   = 32;          // color + start + length, padded

  // Position within a count / color high / color low triplet
  typedef enum logic [1:0] {
    PH_COUNT = 2'd0,
    PH_HIGH  = 2'd1,
    PH_LOW   = 2'd2
  } phase_t;

endpackage

`default_nettype wire

### design/rle_triplet_scanline_expander.sv
// A byte that closes a triplet or a frame loads the job register; its segments are
//   cut into the result register and leave on m_tvalid one a cycle unless m_tready stalls.
// Throughput: one byte per cycle while no job is held; during a job s_tready stays
//   low until its final segment is cut, set by the single segment cutter.
// Reset: rst (synchronous, active high) clears triplet phase, column and valids.
// ----------------------------------------------------------------------------
// rle_triplet_scanline_expander
// Groups coded bytes into count/color triplets and expands each one into run
// segments cut at scanline boundaries, with line and frame end marks.
// ----------------------------------------------------------------------------
`default_nettype none

module rle_triplet_scanline_expander
  import rte_pkg::*;
#(
  parameter int LINE_WIDTH = RTE_LINE_WIDTH
) (
  input  wire logic              clk,
  input  wire logic              rst,
  // input byte stream
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire logic [BYTE_W-1:0] s_tdata,   // [7:0] rle_byte
  input  wire logic              s_tlast,   // last_byte
  // segment stream
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic [OUT_W-1:0]       m_tdata,   // [15:0] pixel_color, [22:16] start_column,
                                            // [29:23] run_length, [31:30] zero
  output logic                   m_tuser,   // [0] line_end
  output logic                   m_tlast    // frame_end
);

  localparam logic [ROOM_W-1:0] LW = ROOM_W'(LINE_WIDTH);

  // triplet assembly state
  phase_t              phase, phase_next;
  logic [BYTE_W-1:0]   held_count, held_count_next;
  logic [BYTE_W-1:0]   held_color_high, held_color_high_next;
  logic [COL_W-1:0]    line_column, line_column_next;

  // job register: one triplet or frame-end marker being cut
  logic                job_valid;
  logic [COLOR_W-1:0]  job_color;
  logic [BYTE_W-1:0]   job_left;
  logic                job_last;

  // result register
  logic [COLOR_W-1:0]  out_color;
  logic [COL_W-1:0]    out_start;
  logic [COL_W-1:0]    out_len;
  logic                out_line_end;
  logic                out_frame_end;

  logic                in_fire, load_job, step_fire, seg_final, marker, fills;
  logic [ROOM_W-1:0]   room, seg_len;
  logic [BYTE_W-1:0]   remain;
  logic [COL_W-1:0]    col_after;

  // segment cutter
  always_comb begin
    room      = LW - {1'b0, line_column};
    seg_len   = (job_left < room) ? job_left : room;
    fills     = (seg_len == room);
    remain    = job_left - seg_len[BYTE_W-1:0];
    marker    = (job_left == '0);
    seg_final = marker || (remain == '0);
    col_after = fills ? '0 : COL_W'(line_column + seg_len[COL_W-1:0]);
  end

  assign step_fire = job_valid && (!m_tvalid || m_tready);
  assign s_tready  = !job_valid || (step_fire && seg_final);
  assign in_fire   = s_tvalid && s_tready;

  // a job starts on a triplet with pixels, or on any last byte
  assign load_job = in_fire && (((phase == PH_LOW) && (held_count != '0)) || s_tlast);

  // triplet assembly
  always_comb begin
    phase_next           = phase;
    held_count_next      = held_count;
    held_color_high_next = held_color_high;
    if (in_fire) begin
      unique case (phase)
        PH_HIGH: begin
          held_color_high_next = s_tdata;
          phase_next           = PH_LOW;
        end
        PH_LOW: begin
          phase_next = PH_COUNT;
        end
        default: begin
          held_count_next = s_tdata;
          phase_next      = PH_HIGH;
        end
      endcase
      if (s_tlast) begin
        phase_next           = PH_COUNT;
        held_count_next      = '0;
        held_color_high_next = '0;
      end
    end
  end

  // column tracking; frame end returns to column zero
  always_comb begin
    line_column_next = line_column;
    if (step_fire) begin
      line_column_next = (job_last && seg_final) ? '0 : col_after;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_COUNT;
      held_count      <= '0;
      held_color_high <= '0;
      line_column     <= '0;
    end else begin
      phase           <= phase_next;
      held_count      <= held_count_next;
      held_color_high <= held_color_high_next;
      line_column     <= line_column_next;
    end
  end

  // job register
  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
    end else if (load_job) begin
      job_valid <= 1'b1;
    end else if (step_fire && seg_final) begin
      job_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_job) begin
      job_color <= {held_color_high, s_tdata};
      job_left  <= (phase == PH_LOW) ? held_count : '0;
      job_last  <= s_tlast;
    end else if (step_fire) begin
      job_left  <= remain;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (step_fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // only the closing segment of a frame flushes a partial line
  always_ff @(posedge clk) begin
    if (step_fire) begin
      out_color     <= marker ? '0 : job_color;
      out_start     <= line_column;
      out_len       <= seg_len[COL_W-1:0];
      out_line_end  <= marker ? (line_column != '0) : (fills || (job_last && seg_final));
      out_frame_end <= job_last && seg_final;
    end
  end

  assign m_tdata = {2'b00, out_len, out_start, out_color};
  assign m_tuser = out_line_end;
  assign m_tlast = out_frame_end;

endmodule

`default_nettype wire

### design/rte_checker.sv
// ----------------------------------------------------------------------------
// rte_checker
// Port-level checks of the scanline expander, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rle_triplet_scanline_expander_macros.svh"

module rte_checker
  import rte_pkg::*;
#(
  parameter int LINE_WIDTH = RTE_LINE_WIDTH
) (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              s_tvalid,
  input wire logic              s_tready,
  input wire logic [BYTE_W-1:0] s_tdata,
  input wire logic              s_tlast,
  input wire logic              m_tvalid,
  input wire logic              m_tready,
  input wire logic [OUT_W-1:0]  m_tdata,
  input wire logic              m_tuser,
  input wire logic              m_tlast
);

  logic [COL_W-1:0]  chk_start, chk_len;
  logic [ROOM_W-1:0] chk_end;

  assign chk_start = m_tdata[22:16];
  assign chk_len   = m_tdata[29:23];
  assign chk_end   = {1'b0, chk_start} + {1'b0, chk_len};

  // no segment straight after reset
  `RTE_ASSERT_ALWAYS(a_rst_idle, rst |=> !m_tvalid, "output valid after reset")

  // a stalled segment holds
  `RTE_ASSERT(a_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled segment changed")

  // a segment never crosses the scanline
  `RTE_ASSERT(a_in_line, m_tvalid |-> (chk_end <= ROOM_W'(LINE_WIDTH)), "segment crosses scanline")

  // empty segments off column zero exist only as frame-end flushes
  `RTE_ASSERT(a_empty_mark, m_tvalid && (chk_len == '0) && (chk_start != '0) |-> m_tlast && m_tuser, "empty segment is not a frame-end flush")

  // a frame end without a line flush is an empty marker at column zero
  `RTE_ASSERT(a_clean_end, m_tvalid && m_tlast && !m_tuser |-> (chk_start == '0) && (chk_len == '0), "frame end left a partial line")

  logic unused_in;
  assign unused_in = s_tvalid ^ s_tready ^ (^s_tdata) ^ s_tlast;

endmodule

bind rle_triplet_scanline_expander rte_checker #(
  .LINE_WIDTH (LINE_WIDTH)
) u_rte_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

`default_nettype wire

### bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the run-length scanline expander. A directed table
// walks the triplet and frame-end corners, then random frames follow, mostly
// well-formed with random counts and colors, some cut short or pure noise.
// Every byte transfer is run through a local scanline model whose segments
// are queued and compared field by field against the segment stream, with
// random stall bursts on both sides.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import rte_pkg::*;

  localparam int LINE_PIX    = RTE_LINE_WIDTH;
  localparam int MAX_SEGS    = 5;
  localparam int RAND_BYTES  = 400;
  localparam int CALM_BYTES  = 60;     // tail of the run with no idling
  localparam int DRAIN_WAIT  = 20;

  // one run segment as it leaves the block
  typedef struct packed {
    logic [15:0] color;
    logic [6:0]  col;
    logic [6:0]  len;
    logic        line_end;
    logic        frame_end;
  } seg_t;

  // how a table row gets its expected segments
  typedef enum logic [1:0] {
    ROW_MODEL,    // from the local model
    ROW_NONE,     // no segment
    ROW_ONE       // the one segment typed in the row
  } row_kind_t;

  typedef struct packed {
    logic [7:0] byte_val;
    logic       is_last;
    row_kind_t  kind;
    seg_t       want;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;     // [7:0] rle_byte
  logic        s_tlast = 1'b0;   // last_byte
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;          // [15:0] pixel_color, [22:16] start_column,
                                 // [29:23] run_length, [31:30] zero
  logic        m_tuser;          // [0] line_end
  logic        m_tlast;          // frame_end

  rle_triplet_scanline_expander dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #4 clk = ~clk;

  // model state
  phase_t     trip_phase = PH_COUNT;
  logic [7:0] count_byte = '0;
  logic [7:0] color_msb  = '0;
  int         column     = 0;

  seg_t       step_segs[$];       // segments caused by the latest byte
  seg_t       expected_segs[$];   // segments still to arrive
  dir_row_t   dir_rows[$];
  int         fail_cnt = 0;
  int         bytes_sent = 0;
  logic       idle_on = 1'b0;
  int         stall_left = 0;
  seg_t       got_seg;
  seg_t       want_seg;

  // Advance the scanline model by one byte; leaves its segments in step_segs
  function automatic void expand_byte(input logic [7:0] b, input logic is_last);
    logic [15:0] color;
    int          left;
    int          room;
    int          seg_len;
    seg_t        s;
    step_segs.delete();
    case (trip_phase)
      PH_HIGH: begin
        color_msb  = b;
        trip_phase = PH_LOW;
      end
      PH_LOW: begin
        color      = {color_msb, b};
        left       = count_byte;
        trip_phase = PH_COUNT;
        // cut the run at scanline boundaries
        while (left > 0 && step_segs.size() < MAX_SEGS) begin
          room        = LINE_PIX - column;
          seg_len     = (left < room) ? left : room;
          s.color     = color;
          s.col       = column[6:0];
          s.len       = seg_len[6:0];
          s.line_end  = (seg_len == room);
          s.frame_end = 1'b0;
          step_segs.push_back(s);
          left   -= seg_len;
          column  = (seg_len == room) ? 0 : column + seg_len;
        end
      end
      default: begin
        // phase three never occurs; treated as the count byte
        count_byte = b;
        trip_phase = PH_HIGH;
      end
    endcase
    // frame close: mark the last segment, or emit a bare marker
    if (is_last) begin
      if (step_segs.size() > 0) begin
        s = step_segs[step_segs.size()-1];
        s.frame_end = 1'b1;
        if (column != 0) s.line_end = 1'b1;
        step_segs[step_segs.size()-1] = s;
      end else begin
        s.color     = '0;
        s.col       = column[6:0];
        s.len       = '0;
        s.line_end  = (column != 0);
        s.frame_end = 1'b1;
        step_segs.push_back(s);
      end
      trip_phase = PH_COUNT;
      count_byte = '0;
      color_msb  = '0;
      column     = 0;
    end
  endfunction

  // Drive one byte and hold it until its transfer
  task automatic send_byte(input logic [7:0] b, input logic is_last);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      gap = $urandom_range(1, 15);
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= is_last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    bytes_sent++;
    if (bytes_sent >= RAND_BYTES - CALM_BYTES) idle_on <= 1'b0;
  endtask

  task automatic send_and_predict(input logic [7:0] b, input logic is_last);
    send_byte(b, is_last);
    expand_byte(b, is_last);
    foreach (step_segs[i]) expected_segs.push_back(step_segs[i]);
  endtask

  task automatic row(input logic [7:0] b, input logic is_last, input row_kind_t kind,
                     input logic [15:0] color, input int col, input int len,
                     input logic le, input logic fe);
    dir_row_t r;
    r.byte_val       = b;
    r.is_last        = is_last;
    r.kind           = kind;
    r.want.color     = color;
    r.want.col       = col[6:0];
    r.want.len       = len[6:0];
    r.want.line_end  = le;
    r.want.frame_end = fe;
    dir_rows.push_back(r);
  endtask

  // Random count, biased toward zero, short runs, line-sized and long runs
  function automatic logic [7:0] pick_count();
    case ($urandom_range(0, 9))
      0:       return 8'd0;
      1, 2:    return 8'($urandom_range(1, 20));
      3, 4:    return 8'($urandom_range(LINE_PIX - 16, LINE_PIX + 16));
      5:       return 8'($urandom_range(200, 255));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_frame();
    int n_trip;
    int tail;
    int n_noise;
    // an occasional frame of plain noise
    if ($urandom_range(0, 9) == 0) begin
      n_noise = $urandom_range(1, 6);
      for (int i = 0; i < n_noise; i++)
        send_and_predict(8'($urandom_range(0, 255)), i == n_noise - 1);
    end else begin
      n_trip = $urandom_range(1, 10);
      case ($urandom_range(0, 9))
        0:       tail = 1;   // stray count byte before the end
        1:       tail = 2;   // count and high byte, no low byte
        default: tail = 0;
      endcase
      for (int t = 0; t < n_trip; t++) begin
        send_and_predict(pick_count(), 1'b0);
        send_and_predict(8'($urandom_range(0, 255)), 1'b0);
        send_and_predict(8'($urandom_range(0, 255)), tail == 0 && t == n_trip - 1);
      end
      for (int k = 0; k < tail; k++)
        send_and_predict(8'($urandom_range(0, 255)), k == tail - 1);
    end
  endtask

  // Output stall bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready   <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(1, 15) - 1;
      m_tready   <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_cnt++;
    end
  endtask

  // Segment checker
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got_seg.color     = m_tdata[15:0];
      got_seg.col       = m_tdata[22:16];
      got_seg.len       = m_tdata[29:23];
      got_seg.line_end  = m_tuser;
      got_seg.frame_end = m_tlast;
      if (expected_segs.size() == 0) begin
        $error("segment with none expected: color %0h col %0d len %0d",
               got_seg.color, got_seg.col, got_seg.len);
        fail_cnt++;
      end else begin
        want_seg = expected_segs.pop_front();
        check_field("pixel_color", want_seg.color, got_seg.color);
        check_field("start_column", want_seg.col, got_seg.col);
        check_field("run_length", want_seg.len, got_seg.len);
        check_field("line_end", want_seg.line_end, got_seg.line_end);
        check_field("frame_end", want_seg.frame_end, got_seg.frame_end);
      end
    end
  end

  // Stimulus
  initial begin
    // directed table: byte, last, kind, typed segment
    row(8'h00, 1'b1, ROW_ONE,  16'h0000, 0,  0, 1'b0, 1'b1);  // lone count byte
    row(8'h05, 1'b0, ROW_NONE, 16'h0000, 0,  0, 1'b0, 1'b0);
    row(8'h12, 1'b1, ROW_ONE,  16'h0000, 0,  0, 1'b0, 1'b1);  // two bytes dropped
    row(8'h60, 1'b0, ROW_NONE, 16'h0000, 0,  0, 1'b0, 1'b0);
    row(8'hFF, 1'b0, ROW_NONE, 16'h0000, 0,  0, 1'b0, 1'b0);
    row(8'hFF, 1'b1, ROW_ONE,  16'hFFFF, 0, 96, 1'b1, 1'b1);  // exact full line
    row(8'h00, 1'b0, ROW_NONE, 16'h0000, 0,  0, 1'b0, 1'b0);  // zero count
    row(8'hAB, 1'b0, ROW_NONE, 16'h0000, 0,  0, 1'b0, 1'b0);
    row(8'hCD, 1'b0, ROW_NONE, 16'h0000, 0,  0, 1'b0, 1'b0);
    row(8'h0A, 1'b0, ROW_NONE, 16'h0000, 0,  0, 1'b0, 1'b0);
    row(8'h12, 1'b0, ROW_NONE, 16'h0000, 0,  0, 1'b0, 1'b0);
    row(8'h34, 1'b0, ROW_ONE,  16'h1234, 0, 10, 1'b0, 1'b0);
    row(8'hFF, 1'b0, ROW_MODEL, 16'h0, 0, 0, 1'b0, 1'b0);     // longest run
    row(8'h80, 1'b0, ROW_MODEL, 16'h0, 0, 0, 1'b0, 1'b0);
    row(8'h01, 1'b0, ROW_MODEL, 16'h0, 0, 0, 1'b0, 1'b0);
    row(8'hC8, 1'b0, ROW_MODEL, 16'h0, 0, 0, 1'b0, 1'b0);
    row(8'h00, 1'b0, ROW_MODEL, 16'h0, 0, 0, 1'b0, 1'b0);
    row(8'h00, 1'b0, ROW_MODEL, 16'h0, 0, 0, 1'b0, 1'b0);
    row(8'h07, 1'b0, ROW_MODEL, 16'h0, 0, 0, 1'b0, 1'b0);     // partial line flush
    row(8'h55, 1'b0, ROW_MODEL, 16'h0, 0, 0, 1'b0, 1'b0);
    row(8'hAA, 1'b1, ROW_MODEL, 16'h0, 0, 0, 1'b0, 1'b0);
    row(8'h14, 1'b0, ROW_MODEL, 16'h0, 0, 0, 1'b0, 1'b0);
    row(8'h01, 1'b0, ROW_MODEL, 16'h0, 0, 0, 1'b0, 1'b0);
    row(8'h02, 1'b0, ROW_MODEL, 16'h0, 0, 0, 1'b0, 1'b0);
    row(8'h33, 1'b1, ROW_MODEL, 16'h0, 0, 0, 1'b0, 1'b0);     // marker on open line

    repeat (4) @(posedge clk);
    rst     <= 1'b0;
    idle_on <= 1'b1;

    foreach (dir_rows[i]) begin
      send_byte(dir_rows[i].byte_val, dir_rows[i].is_last);
      expand_byte(dir_rows[i].byte_val, dir_rows[i].is_last);
      case (dir_rows[i].kind)
        ROW_ONE:   expected_segs.push_back(dir_rows[i].want);
        ROW_MODEL: foreach (step_segs[j]) expected_segs.push_back(step_segs[j]);
        default:   ;
      endcase
    end

    bytes_sent = 0;
    while (bytes_sent < RAND_BYTES) send_frame();
    s_tvalid <= 1'b0;

    while (expected_segs.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Timeout
  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

`default_nettype wire

### filelist.f
+incdir+design
design/rte_pkg.sv
design/rle_triplet_scanline_expander.sv
design/rte_checker.sv
bench/tb_top.sv
